// ----- hdl/qcsa_pkg.sv -----
// shared types, widths and constants for the quad corner skew angle block
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package qcsa_pkg;

    // field and datapath widths
    localparam int CW          = 20;  // corner coordinate, signed q16.4
    localparam int SUMW        = 22;  // sum of four corners
    localparam int CXW         = 24;  // centred coordinate, signed
    localparam int AW          = 22;  // magnitude of a centred coordinate
    localparam int SQW         = 46;  // square sums and root working width
    localparam int RW          = 23;  // integer root
    localparam int SHW         = 24;  // sum of magnitudes
    localparam int SVW         = 25;  // signed sum of magnitudes
    localparam int PW          = 49;  // product width
    localparam int LVW         = 24;  // line or midline direction
    localparam int VW          = 56;  // angle lane x and y
    localparam int ZW          = 26;  // angle accumulator, 1/65536 degree
    localparam int DW          = 28;  // angle difference
    localparam int RDW         = 20;  // difference after rounding to q8.8
    localparam int QW          = 17;  // result angle, signed q8.8

    // bus widths
    localparam int IN_TW       = 160;
    localparam int OUT_TW      = 72;

    // pipeline shape
    localparam int ISQ_STEPS    = 23;
    localparam int CORDIC_ITERS = 22;
    localparam int NORM_STAGES  = 6;
    localparam int NORM_TOP     = 51;
    localparam int LANES        = 7;
    localparam int PIPE_DEPTH   = 4 + ISQ_STEPS + 2 + NORM_STAGES + 1 + CORDIC_ITERS + 2;

    // lane assignment
    localparam int LANE_CONF  = 0;
    localparam int LANE_LR    = 1;
    localparam int LANE_TB    = 2;
    localparam int LANE_TOP   = 3;
    localparam int LANE_BOT   = 4;
    localparam int LANE_LEFT  = 5;
    localparam int LANE_RIGHT = 6;

    // angle constants
    localparam logic signed [ZW-1:0] ANG90  = ZW'(5898240);
    localparam logic signed [ZW-1:0] ANG180 = ZW'(11796480);
    localparam int FULL_Q88 = 92160;
    localparam int HALF_Q88 = 46080;

    typedef struct packed {
        logic signed [CW-1:0] tl_x;
        logic signed [CW-1:0] tl_y;
        logic signed [CW-1:0] tr_x;
        logic signed [CW-1:0] tr_y;
        logic signed [CW-1:0] bl_x;
        logic signed [CW-1:0] bl_y;
        logic signed [CW-1:0] br_x;
        logic signed [CW-1:0] br_y;
    } corners_t;

    typedef struct packed {
        logic signed [LVW-1:0] x;
        logic signed [LVW-1:0] y;
    } lvec_t;

    // sums of the conformal fit and the six line directions
    typedef struct packed {
        logic        [SHW-1:0] sxh;
        logic        [SHW-1:0] syh;
        logic signed [SVW-1:0] sxv;
        logic signed [SVW-1:0] syv;
        lvec_t                 lr;
        lvec_t                 tb;
        lvec_t                 top;
        lvec_t                 bot;
        lvec_t                 lft;
        lvec_t                 rgt;
    } side_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } vec_t;

    // one angle lane between cells
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cord_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ZW-1:0] step_angle(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = ZW'(2949120);
            1:       a = ZW'(1740967);
            2:       a = ZW'(919879);
            3:       a = ZW'(466945);
            4:       a = ZW'(234379);
            5:       a = ZW'(117304);
            6:       a = ZW'(58666);
            7:       a = ZW'(29335);
            8:       a = ZW'(14668);
            9:       a = ZW'(7334);
            10:      a = ZW'(3667);
            11:      a = ZW'(1833);
            12:      a = ZW'(917);
            13:      a = ZW'(458);
            14:      a = ZW'(229);
            15:      a = ZW'(115);
            16:      a = ZW'(57);
            17:      a = ZW'(29);
            18:      a = ZW'(14);
            19:      a = ZW'(7);
            20:      a = ZW'(4);
            21:      a = ZW'(2);
            default: a = '0;
        endcase
        return a;
    endfunction

    // trial bit of root step k, highest first
    function automatic logic [SQW-1:0] isq_bit(input int k);
        return SQW'(1) << (2 * (ISQ_STEPS - 1 - k));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/quad_corner_skew_angles_top.sv -----
// Quad corner skew angles, top level.
// Input stream: one word per page quadrilateral. tdata carries the eight
// corner coordinates (signed q16.4), tuser[0] the model valid flag.
// Output stream: one word per input word, four signed q8.8 angles wrapped
// to (-180,180]: conformal skew, oblique angle, horizontal and vertical
// spread. A word with model valid low gives four zeros.
// Path from input accept to output valid with no stall:
// 4 front stages, 23 root cells, 2 product stages, 7 normalize stages,
// 22 rotation cells per angle lane, 2 output stages, 1 output register.
// Throughput: one word per cycle while the skid register is free; the
// rotation cell chains of the seven angle lanes are fully pipelined.
// Reset clears all valid flags, also the output valid; s_axis_tready is
// high out of reset. When the receiver stalls, the output register holds
// its word and a skid register takes one more; only when the skid register
// is full does the whole pipeline freeze and s_axis_tready drop.
// Depends on qcsa_pkg, qcsa_front, qcsa_isqrt_cell, qcsa_norm, qcsa_cordic_cell.
`default_nettype none

module quad_corner_skew_angles_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // top_left_x, top_left_y, top_right_x, top_right_y,
    // bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y
    input  wire logic [qcsa_pkg::IN_TW-1:0]    s_axis_tdata,
    // model_valid
    input  wire logic [0:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // conformal_angle, oblique_angle, horizontal_spread, vertical_spread, zero fill
    output logic [qcsa_pkg::OUT_TW-1:0]        m_axis_tdata
);

    localparam int L = qcsa_pkg::PIPE_DEPTH;

    logic                               en;
    qcsa_pkg::corners_t                 corners;
    logic                               vld_reg [L];
    logic                               mv_reg [L];
    logic [qcsa_pkg::SQW-1:0]           sxx, syy;
    qcsa_pkg::side_t                    side;
    logic [qcsa_pkg::SQW-1:0]           nx_s [qcsa_pkg::ISQ_STEPS+1];
    logic [qcsa_pkg::SQW-1:0]           rx_s [qcsa_pkg::ISQ_STEPS+1];
    logic [qcsa_pkg::SQW-1:0]           ny_s [qcsa_pkg::ISQ_STEPS+1];
    logic [qcsa_pkg::SQW-1:0]           ry_s [qcsa_pkg::ISQ_STEPS+1];
    qcsa_pkg::side_t                    side_dly_reg [qcsa_pkg::ISQ_STEPS];
    logic [qcsa_pkg::RW-1:0]            rx, ry;
    logic [qcsa_pkg::PW-1:0]            phx_reg, phy_reg;
    logic signed [qcsa_pkg::PW-1:0]     pvy_reg, pvx_reg;
    qcsa_pkg::side_t                    side_p_reg;
    logic [qcsa_pkg::PW-1:0]            dx;
    logic signed [qcsa_pkg::PW:0]       dy;
    qcsa_pkg::vec_t                     vec_next [qcsa_pkg::LANES];
    qcsa_pkg::vec_t                     vec_reg [qcsa_pkg::LANES];
    qcsa_pkg::cord_t                    cord_s [qcsa_pkg::LANES][qcsa_pkg::CORDIC_ITERS+1];
    logic signed [qcsa_pkg::ZW-1:0]     zf [qcsa_pkg::LANES];
    logic signed [qcsa_pkg::DW-1:0]     diff_next [4];
    logic signed [qcsa_pkg::DW-1:0]     diff_reg [4];
    logic signed [qcsa_pkg::QW-1:0]     ang_next [4];
    logic signed [qcsa_pkg::QW-1:0]     ang_reg [4];
    logic [qcsa_pkg::OUT_TW-1:0]        res_word;
    logic                               push, pop;
    logic                               out_vld_reg, out_vld_next;
    logic                               skid_vld_reg, skid_vld_next;
    logic [qcsa_pkg::OUT_TW-1:0]        out_dat_reg, out_dat_next;
    logic [qcsa_pkg::OUT_TW-1:0]        skid_dat_reg, skid_dat_next;

    // round to q8.8 and wrap into (-180,180]
    function automatic logic signed [qcsa_pkg::QW-1:0] to_q88(
        input logic signed [qcsa_pkg::DW-1:0] d);
        logic signed [qcsa_pkg::DW-1:0]  t;
        logic signed [qcsa_pkg::RDW-1:0] r;
        t = (d + qcsa_pkg::DW'(128)) >>> 8;
        r = qcsa_pkg::RDW'(t);
        if (r > qcsa_pkg::HALF_Q88)
        begin
            r = qcsa_pkg::RDW'(r - qcsa_pkg::FULL_Q88);
        end
        else if (r <= -qcsa_pkg::HALF_Q88)
        begin
            r = qcsa_pkg::RDW'(r + qcsa_pkg::FULL_Q88);
        end
        return qcsa_pkg::QW'(r);
    endfunction

    // pipeline moves while the skid register is free
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    // unpack the input word
    always_comb
    begin
        corners.tl_x = s_axis_tdata[0*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.tl_y = s_axis_tdata[1*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.tr_x = s_axis_tdata[2*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.tr_y = s_axis_tdata[3*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.bl_x = s_axis_tdata[4*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.bl_y = s_axis_tdata[5*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.br_x = s_axis_tdata[6*qcsa_pkg::CW +: qcsa_pkg::CW];
        corners.br_y = s_axis_tdata[7*qcsa_pkg::CW +: qcsa_pkg::CW];
    end

    // valid and model flag ride along every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                vld_reg[k] <= 1'b0;
                mv_reg[k]  <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            mv_reg[0]  <= s_axis_tuser[0];
            for (int k = 1; k < L; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
                mv_reg[k]  <= mv_reg[k-1];
            end
        end
    end

    qcsa_front u_front (
        .clk     (clk),
        .en      (en),
        .corners (corners),
        .sxx     (sxx),
        .syy     (syy),
        .side    (side)
    );

    // square root chains for both square sums
    assign nx_s[0] = sxx;
    assign rx_s[0] = '0;
    assign ny_s[0] = syy;
    assign ry_s[0] = '0;

    for (genvar k = 0; k < qcsa_pkg::ISQ_STEPS; k++)
    begin : g_isq
        qcsa_isqrt_cell u_cx (
            .clk       (clk),
            .en        (en),
            .trial_bit (qcsa_pkg::isq_bit(k)),
            .n_in      (nx_s[k]),
            .r_in      (rx_s[k]),
            .n_out     (nx_s[k+1]),
            .r_out     (rx_s[k+1])
        );
        qcsa_isqrt_cell u_cy (
            .clk       (clk),
            .en        (en),
            .trial_bit (qcsa_pkg::isq_bit(k)),
            .n_in      (ny_s[k]),
            .r_in      (ry_s[k]),
            .n_out     (ny_s[k+1]),
            .r_out     (ry_s[k+1])
        );
    end

    // sums and line directions wait beside the root chains
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side;
            for (int k = 1; k < qcsa_pkg::ISQ_STEPS; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    assign rx = rx_s[qcsa_pkg::ISQ_STEPS][qcsa_pkg::RW-1:0];
    assign ry = ry_s[qcsa_pkg::ISQ_STEPS][qcsa_pkg::RW-1:0];

    // products of the fit direction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phx_reg    <= qcsa_pkg::PW'(side_dly_reg[qcsa_pkg::ISQ_STEPS-1].sxh)
                        * qcsa_pkg::PW'(rx);
            phy_reg    <= qcsa_pkg::PW'(side_dly_reg[qcsa_pkg::ISQ_STEPS-1].syh)
                        * qcsa_pkg::PW'(ry);
            pvy_reg    <= side_dly_reg[qcsa_pkg::ISQ_STEPS-1].sxv * $signed({1'b0, ry});
            pvx_reg    <= side_dly_reg[qcsa_pkg::ISQ_STEPS-1].syv * $signed({1'b0, rx});
            side_p_reg <= side_dly_reg[qcsa_pkg::ISQ_STEPS-1];
        end
    end

    // fit direction and the six line vectors enter the angle lanes
    always_comb
    begin
        dx = phx_reg + phy_reg;
        dy = (qcsa_pkg::PW+1)'(pvy_reg) - (qcsa_pkg::PW+1)'(pvx_reg);
        vec_next[qcsa_pkg::LANE_CONF].x  = qcsa_pkg::VW'(dx);
        vec_next[qcsa_pkg::LANE_CONF].y  = -qcsa_pkg::VW'(dy);
        vec_next[qcsa_pkg::LANE_LR].x    = qcsa_pkg::VW'(side_p_reg.lr.x);
        vec_next[qcsa_pkg::LANE_LR].y    = qcsa_pkg::VW'(side_p_reg.lr.y);
        vec_next[qcsa_pkg::LANE_TB].x    = qcsa_pkg::VW'(side_p_reg.tb.x);
        vec_next[qcsa_pkg::LANE_TB].y    = qcsa_pkg::VW'(side_p_reg.tb.y);
        vec_next[qcsa_pkg::LANE_TOP].x   = qcsa_pkg::VW'(side_p_reg.top.x);
        vec_next[qcsa_pkg::LANE_TOP].y   = qcsa_pkg::VW'(side_p_reg.top.y);
        vec_next[qcsa_pkg::LANE_BOT].x   = qcsa_pkg::VW'(side_p_reg.bot.x);
        vec_next[qcsa_pkg::LANE_BOT].y   = qcsa_pkg::VW'(side_p_reg.bot.y);
        vec_next[qcsa_pkg::LANE_LEFT].x  = qcsa_pkg::VW'(side_p_reg.lft.x);
        vec_next[qcsa_pkg::LANE_LEFT].y  = qcsa_pkg::VW'(side_p_reg.lft.y);
        vec_next[qcsa_pkg::LANE_RIGHT].x = qcsa_pkg::VW'(side_p_reg.rgt.x);
        vec_next[qcsa_pkg::LANE_RIGHT].y = qcsa_pkg::VW'(side_p_reg.rgt.y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    // seven angle lanes: normalize, then a row of rotation cells
    for (genvar l = 0; l < qcsa_pkg::LANES; l++)
    begin : g_lane
        qcsa_norm u_norm (
            .clk  (clk),
            .en   (en),
            .vin  (vec_reg[l]),
            .vout (cord_s[l][0])
        );
        for (genvar i = 0; i < qcsa_pkg::CORDIC_ITERS; i++)
        begin : g_cell
            qcsa_cordic_cell u_cell (
                .clk   (clk),
                .en    (en),
                .shift (5'(i)),
                .step  (qcsa_pkg::step_angle(i)),
                .cin   (cord_s[l][i]),
                .cout  (cord_s[l][i+1])
            );
        end
        assign zf[l] = cord_s[l][qcsa_pkg::CORDIC_ITERS].zero ? '0
                     : cord_s[l][qcsa_pkg::CORDIC_ITERS].z;
    end

    // angle differences
    always_comb
    begin
        diff_next[0] = qcsa_pkg::DW'(zf[qcsa_pkg::LANE_CONF]);
        diff_next[1] = qcsa_pkg::DW'(zf[qcsa_pkg::LANE_TB]) + qcsa_pkg::DW'(qcsa_pkg::ANG90)
                     - qcsa_pkg::DW'(zf[qcsa_pkg::LANE_LR]);
        diff_next[2] = qcsa_pkg::DW'(zf[qcsa_pkg::LANE_BOT])
                     - qcsa_pkg::DW'(zf[qcsa_pkg::LANE_TOP]);
        diff_next[3] = qcsa_pkg::DW'(zf[qcsa_pkg::LANE_RIGHT])
                     - qcsa_pkg::DW'(zf[qcsa_pkg::LANE_LEFT]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
        end
    end

    // rounding, wrap and invalid-model zeroing
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            ang_next[j] = mv_reg[L-2] ? to_q88(diff_reg[j]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= ang_next;
        end
    end

    assign res_word = {4'b0000, ang_reg[3], ang_reg[2], ang_reg[1], ang_reg[0]};

    // output register with one skid word
    always_comb
    begin
        push          = en && vld_reg[L-1];
        pop           = out_vld_reg && m_axis_tready;
        out_vld_next  = out_vld_reg;
        out_dat_next  = out_dat_reg;
        skid_vld_next = skid_vld_reg;
        skid_dat_next = skid_dat_reg;
        if (pop)
        begin
            if (skid_vld_reg)
            begin
                out_dat_next  = skid_dat_reg;
                skid_vld_next = 1'b0;
            end
            else if (push)
            begin
                out_dat_next = res_word;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg)
            begin
                out_vld_next = 1'b1;
                out_dat_next = res_word;
            end
            else
            begin
                skid_vld_next = 1'b1;
                skid_dat_next = res_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dat_reg  <= out_dat_next;
        skid_dat_reg <= skid_dat_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_dat_reg;

endmodule

`default_nettype wire

// ----- hdl/qcsa_front.sv -----
// front stages: corner capture, centring, squares and sums of the conformal fit
// uses qcsa_pkg; feeds the root cells and the side delay line of the top level
`default_nettype none

module qcsa_front (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire qcsa_pkg::corners_t         corners,
    output logic [qcsa_pkg::SQW-1:0]        sxx,
    output logic [qcsa_pkg::SQW-1:0]        syy,
    output qcsa_pkg::side_t                 side
);

    qcsa_pkg::corners_t                  cor_reg;
    logic signed [qcsa_pkg::CW-1:0]      px [4];
    logic signed [qcsa_pkg::CW-1:0]      py [4];
    logic signed [qcsa_pkg::SUMW-1:0]    sumx, sumy;
    logic signed [qcsa_pkg::CXW-1:0]     cx [4];
    logic signed [qcsa_pkg::CXW-1:0]     cy [4];
    logic [qcsa_pkg::AW-1:0]             ax_next [4];
    logic [qcsa_pkg::AW-1:0]             ay_next [4];
    logic                                neg_next [4];
    logic [qcsa_pkg::AW-1:0]             ax_reg [4];
    logic [qcsa_pkg::AW-1:0]             ay_reg [4];
    logic                                neg_reg [4];
    qcsa_pkg::side_t                     line_next, side2_reg;
    logic [2*qcsa_pkg::AW-1:0]           sqx_next [4];
    logic [2*qcsa_pkg::AW-1:0]           sqy_next [4];
    logic [2*qcsa_pkg::AW-1:0]           sqx_reg [4];
    logic [2*qcsa_pkg::AW-1:0]           sqy_reg [4];
    qcsa_pkg::side_t                     side3_next, side3_reg;
    logic [qcsa_pkg::SQW-1:0]            sxx_next, syy_next, sxx_reg, syy_reg;
    qcsa_pkg::side_t                     side4_reg;

    // corner capture
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cor_reg <= corners;
        end
    end

    // corner order: top-left, top-right, bottom-left, bottom-right
    always_comb
    begin
        px[0] = cor_reg.tl_x;  py[0] = cor_reg.tl_y;
        px[1] = cor_reg.tr_x;  py[1] = cor_reg.tr_y;
        px[2] = cor_reg.bl_x;  py[2] = cor_reg.bl_y;
        px[3] = cor_reg.br_x;  py[3] = cor_reg.br_y;
    end

    // centring on the mean, scaled by four so it stays exact
    always_comb
    begin
        sumx = '0;
        sumy = '0;
        for (int j = 0; j < 4; j++)
        begin
            sumx = sumx + qcsa_pkg::SUMW'(px[j]);
            sumy = sumy + qcsa_pkg::SUMW'(py[j]);
        end
        for (int j = 0; j < 4; j++)
        begin
            cx[j] = (qcsa_pkg::CXW'(px[j]) <<< 2) - qcsa_pkg::CXW'(sumx);
            cy[j] = (qcsa_pkg::CXW'(py[j]) <<< 2) - qcsa_pkg::CXW'(sumy);
            ax_next[j] = cx[j][qcsa_pkg::CXW-1] ? qcsa_pkg::AW'(-cx[j])
                                                 : qcsa_pkg::AW'(cx[j]);
            ay_next[j] = cy[j][qcsa_pkg::CXW-1] ? qcsa_pkg::AW'(-cy[j])
                                                 : qcsa_pkg::AW'(cy[j]);
            neg_next[j] = (cx[j] > 0 && cy[j] < 0) || (cx[j] < 0 && cy[j] > 0);
        end
    end

    // line directions, y flipped for the y-down image frame
    always_comb
    begin
        line_next     = '0;
        line_next.lr.x  = qcsa_pkg::LVW'(px[1]) + qcsa_pkg::LVW'(px[3])
                        - qcsa_pkg::LVW'(px[0]) - qcsa_pkg::LVW'(px[2]);
        line_next.lr.y  = qcsa_pkg::LVW'(py[0]) + qcsa_pkg::LVW'(py[2])
                        - qcsa_pkg::LVW'(py[1]) - qcsa_pkg::LVW'(py[3]);
        line_next.tb.x  = qcsa_pkg::LVW'(px[2]) + qcsa_pkg::LVW'(px[3])
                        - qcsa_pkg::LVW'(px[0]) - qcsa_pkg::LVW'(px[1]);
        line_next.tb.y  = qcsa_pkg::LVW'(py[0]) + qcsa_pkg::LVW'(py[1])
                        - qcsa_pkg::LVW'(py[2]) - qcsa_pkg::LVW'(py[3]);
        line_next.top.x = qcsa_pkg::LVW'(px[1]) - qcsa_pkg::LVW'(px[0]);
        line_next.top.y = qcsa_pkg::LVW'(py[0]) - qcsa_pkg::LVW'(py[1]);
        line_next.bot.x = qcsa_pkg::LVW'(px[3]) - qcsa_pkg::LVW'(px[2]);
        line_next.bot.y = qcsa_pkg::LVW'(py[2]) - qcsa_pkg::LVW'(py[3]);
        line_next.lft.x = qcsa_pkg::LVW'(px[2]) - qcsa_pkg::LVW'(px[0]);
        line_next.lft.y = qcsa_pkg::LVW'(py[0]) - qcsa_pkg::LVW'(py[2]);
        line_next.rgt.x = qcsa_pkg::LVW'(px[3]) - qcsa_pkg::LVW'(px[1]);
        line_next.rgt.y = qcsa_pkg::LVW'(py[1]) - qcsa_pkg::LVW'(py[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            neg_reg   <= neg_next;
            side2_reg <= line_next;
        end
    end

    // squares and magnitude sums
    always_comb
    begin
        side3_next     = side2_reg;
        side3_next.sxh = '0;
        side3_next.syh = '0;
        side3_next.sxv = '0;
        side3_next.syv = '0;
        for (int j = 0; j < 4; j++)
        begin
            sqx_next[j] = ax_reg[j] * ax_reg[j];
            sqy_next[j] = ay_reg[j] * ay_reg[j];
            side3_next.sxh = side3_next.sxh + qcsa_pkg::SHW'(ax_reg[j]);
            side3_next.syh = side3_next.syh + qcsa_pkg::SHW'(ay_reg[j]);
            if (neg_reg[j])
            begin
                side3_next.sxv = side3_next.sxv - $signed(qcsa_pkg::SVW'(ax_reg[j]));
                side3_next.syv = side3_next.syv - $signed(qcsa_pkg::SVW'(ay_reg[j]));
            end
            else
            begin
                side3_next.sxv = side3_next.sxv + $signed(qcsa_pkg::SVW'(ax_reg[j]));
                side3_next.syv = side3_next.syv + $signed(qcsa_pkg::SVW'(ay_reg[j]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            side3_reg <= side3_next;
        end
    end

    // square sums
    always_comb
    begin
        sxx_next = '0;
        syy_next = '0;
        for (int j = 0; j < 4; j++)
        begin
            sxx_next = sxx_next + qcsa_pkg::SQW'(sqx_reg[j]);
            syy_next = syy_next + qcsa_pkg::SQW'(sqy_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            side4_reg <= side3_reg;
        end
    end

    assign sxx  = sxx_reg;
    assign syy  = syy_reg;
    assign side = side4_reg;

endmodule

`default_nettype wire

// ----- hdl/qcsa_isqrt_cell.sv -----
// one step of the digit-by-digit integer square root, one result bit per cell
// uses qcsa_pkg for widths; the trial bit comes in as a tied constant
`default_nettype none

module qcsa_isqrt_cell (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [qcsa_pkg::SQW-1:0]   trial_bit,
    input  wire logic [qcsa_pkg::SQW-1:0]   n_in,
    input  wire logic [qcsa_pkg::SQW-1:0]   r_in,
    output logic [qcsa_pkg::SQW-1:0]        n_out,
    output logic [qcsa_pkg::SQW-1:0]        r_out
);

    logic [qcsa_pkg::SQW-1:0] trial;
    logic [qcsa_pkg::SQW-1:0] n_next, r_next, n_reg, r_reg;

    // subtract when the remainder holds the trial value
    always_comb
    begin
        trial = r_in + trial_bit;
        if (n_in >= trial)
        begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + trial_bit;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule

`default_nettype wire

// ----- hdl/qcsa_norm.sv -----
// quadrant fold and left-justifying shift of one angle lane, seven stages
// uses qcsa_pkg; output goes to the first rotation cell of the lane
`default_nettype none

module qcsa_norm (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire qcsa_pkg::vec_t   vin,
    output qcsa_pkg::cord_t       vout
);

    typedef struct packed {
        qcsa_pkg::cord_t             c;
        logic [qcsa_pkg::VW-1:0]     v;
    } nrm_t;

    nrm_t                        fold_next;
    nrm_t                        nrm_reg [qcsa_pkg::NORM_STAGES+1];
    logic signed [qcsa_pkg::VW-1:0] yq;

    // fold the left half plane onto the right one, add half a turn
    always_comb
    begin
        fold_next        = '0;
        fold_next.c.zero = (vin.x == '0) && (vin.y == '0);
        if (vin.x[qcsa_pkg::VW-1])
        begin
            fold_next.c.x = -vin.x;
            fold_next.c.y = -vin.y;
            fold_next.c.z = qcsa_pkg::ANG180;
        end
        else
        begin
            fold_next.c.x = vin.x;
            fold_next.c.y = vin.y;
            fold_next.c.z = '0;
        end
        yq          = fold_next.c.y[qcsa_pkg::VW-1] ? -fold_next.c.y : fold_next.c.y;
        fold_next.v = fold_next.c.x | yq;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_reg[0] <= fold_next;
        end
    end

    // binary shift search: 32, 16, 8, 4, 2, 1
    for (genvar k = 1; k <= qcsa_pkg::NORM_STAGES; k++)
    begin : g_shift
        localparam int SH = 1 << (qcsa_pkg::NORM_STAGES - k);
        nrm_t stg_next;

        always_comb
        begin
            stg_next = nrm_reg[k-1];
            if (nrm_reg[k-1].v < (qcsa_pkg::VW'(1) << (qcsa_pkg::NORM_TOP - SH)))
            begin
                stg_next.c.x = nrm_reg[k-1].c.x <<< SH;
                stg_next.c.y = nrm_reg[k-1].c.y <<< SH;
                stg_next.v   = nrm_reg[k-1].v << SH;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nrm_reg[k] <= stg_next;
            end
        end
    end

    assign vout = nrm_reg[qcsa_pkg::NORM_STAGES].c;

endmodule

`default_nettype wire

// ----- hdl/qcsa_cordic_cell.sv -----
// one vectoring rotation of an angle lane; shift and step angle are tied constants
// uses qcsa_pkg for the lane struct
`default_nettype none

module qcsa_cordic_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [4:0]                    shift,
    input  wire logic signed [qcsa_pkg::ZW-1:0] step,
    input  wire qcsa_pkg::cord_t               cin,
    output qcsa_pkg::cord_t                    cout
);

    logic signed [qcsa_pkg::VW-1:0] xs, ys;
    qcsa_pkg::cord_t                c_next, c_reg;

    // rotate toward the x axis, floor shifts
    always_comb
    begin
        xs     = cin.x >>> shift;
        ys     = cin.y >>> shift;
        c_next = cin;
        if (!cin.y[qcsa_pkg::VW-1])
        begin
            c_next.x = cin.x + ys;
            c_next.y = cin.y - xs;
            c_next.z = cin.z + step;
        end
        else
        begin
            c_next.x = cin.x - ys;
            c_next.y = cin.y + xs;
            c_next.z = cin.z - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    assign cout = c_reg;

endmodule

`default_nettype wire

// ----- hdl/quad_corner_skew_angles_checker.sv -----
// port-level checks of the quad corner skew angle block, bound to the top level
// uses qcsa_pkg for bus widths
`default_nettype none

module quad_corner_skew_angles_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [qcsa_pkg::OUT_TW-1:0]   m_axis_tdata
);

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed under stall");

    // input side only backs off while an output word is waiting
    a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // every angle wrapped into (-180,180]
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[16:0])  > -17'sd46080 &&
            $signed(m_axis_tdata[16:0])  <=  17'sd46080 &&
            $signed(m_axis_tdata[33:17]) > -17'sd46080 &&
            $signed(m_axis_tdata[33:17]) <=  17'sd46080 &&
            $signed(m_axis_tdata[50:34]) > -17'sd46080 &&
            $signed(m_axis_tdata[50:34]) <=  17'sd46080 &&
            $signed(m_axis_tdata[67:51]) > -17'sd46080 &&
            $signed(m_axis_tdata[67:51]) <=  17'sd46080)
        else $error("angle outside wrap range");

    // fill bits of the output word are zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:68] == 4'b0000)
        else $error("nonzero fill bits");

endmodule

bind quad_corner_skew_angles_top quad_corner_skew_angles_checker u_checker (.*);

`default_nettype wire
